// ===== rtl/phm_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// phm_pkg
// shared types and constants of the chained hash map core
// ---------------------------------------------------------------------------
package phm_pkg;

   localparam logic [63:0] HASH_MUL = 64'h2545_F491_4F6C_DD1D;
   localparam int HASH_PRE_SHIFT = 15;
   localparam int HASH_POST_SHIFT = 13;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_SET_TAIL = 2'd3;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic hash;
      logic head_rd;
      logic ins_wr;
      logic tail_wr;
      logic walk_start;
      logic node_rd;
      logic advance;
      logic found_ld;
      logic miss;
      logic unlink;
      logic free_wr;
      logic rsp_ld;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic [1:0] op;
      logic cur_null;
      logic key_eq;
      logic rsp_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/pointer_keyed_hash_map_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pointer_keyed_hash_map_core
// chained hash map from a 64-bit key to a 64-bit value with a tail register
// ---------------------------------------------------------------------------
// after reset the block sweeps the bucket head memory, clearing every bucket,
// and takes no word until then. a command then works through registered
// reads of the bucket and entry memories: set tail writes the tail register,
// insert hashes the key, reads the bucket head and links the new entry in,
// lookup and remove walk the chain entry by entry, and remove unlinks and
// frees the entry on a hit. one command is in flight at a time; the result
// register lets the next word in while a result waits.
module pointer_keyed_hash_map_core #(
   parameter int BUCKETS = 256,
   parameter int ENTRIES = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,  // key, value
   input  wire logic [1:0]   req_tuser,  // command
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,  // found_value, tail_value
   output logic [1:0]        rsp_tuser   // status
);
   import phm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   phm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   phm_dp #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_command     (req_tuser),
      .req_key         (req_tdata[63:0]),
      .req_value       (req_tdata[127:64]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_status      (rsp_tuser),
      .rsp_found_value (rsp_tdata[63:0]),
      .rsp_tail_value  (rsp_tdata[127:64])
   );

endmodule
`default_nettype wire

// ===== rtl/phm_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// phm_ram
// simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module phm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/phm_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// phm_ctrl
// command sequencer: bucket clear sweep, hashing, chain walk and update
// ---------------------------------------------------------------------------
module phm_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire phm_pkg::sts_type sts,
   output phm_pkg::cmd_type     cmd
);
   import phm_pkg::*;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_HASH   = 4'd2;
   localparam logic [3:0] S_HEAD   = 4'd3;
   localparam logic [3:0] S_FETCH  = 4'd4;
   localparam logic [3:0] S_NODE   = 4'd5;
   localparam logic [3:0] S_CMP    = 4'd6;
   localparam logic [3:0] S_UNLINK = 4'd7;
   localparam logic [3:0] S_FREE   = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (sts.op == OP_SET_TAIL) begin
               cmd.tail_wr = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.hash = 1'b1;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            if (sts.op == OP_INSERT) begin
               cmd.ins_wr = 1'b1;
               cmd.tail_wr = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.walk_start = 1'b1;
               state_in = S_NODE;
            end
         end
         S_NODE: begin
            if (sts.cur_null) begin
               cmd.miss = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.node_rd = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.key_eq) begin
               if (sts.op == OP_LOOKUP) begin
                  cmd.found_ld = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_UNLINK;
               end
            end else begin
               cmd.advance = 1'b1;
               state_in = S_NODE;
            end
         end
         S_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in = S_FREE;
         end
         S_FREE: begin
            cmd.free_wr = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_ld = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/phm_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// phm_dp
// hash unit, bucket and entry memories, chain pointers and result register
// ---------------------------------------------------------------------------
module phm_dp #(
   parameter int BUCKETS = 256,
   parameter int ENTRIES = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire phm_pkg::cmd_type cmd,
   output phm_pkg::sts_type      sts,
   input  wire logic [1:0]       req_command,
   input  wire logic [63:0]      req_key,
   input  wire logic [63:0]      req_value,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [1:0]            rsp_status,
   output logic [63:0]           rsp_found_value,
   output logic [63:0]           rsp_tail_value
);
   import phm_pkg::*;

   localparam int BW = $clog2(BUCKETS);
   localparam int EW = $clog2(ENTRIES);
   localparam int LW = $clog2(ENTRIES + 1);
   localparam int HW = BW + HASH_POST_SHIFT;
   localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);
   localparam logic [HW-1:0] MUL_LO = HASH_MUL[HW-1:0];

   logic [1:0]    op_ff;
   logic [63:0]   key_ff;
   logic [63:0]   val_ff;
   logic [HW-1:0] prod_ff;
   logic [BW-1:0] bkt_ff;
   logic [BW-1:0] clr_ff;
   logic [LW-1:0] free_ff;
   logic [LW-1:0] fresh_ff;
   logic [LW-1:0] cur_ff;
   logic [LW-1:0] prev_ff;
   logic [LW-1:0] nxt_ff;
   logic [63:0]   tail_ff;
   logic [63:0]   found_ff;
   logic [1:0]    status_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [63:0]   rsp_found_ff;
   logic [63:0]   rsp_tail_ff;

   logic [63:0]   key_mix;
   logic [HW-1:0] prod_in;
   logic [HW-1:0] folded;
   logic [BW-1:0] bkt_idx;
   logic          free_ok;
   logic          fresh_ok;
   logic          slot_ok;
   logic [LW-1:0] slot;
   logic          prev_null;

   logic          bh_we;
   logic [BW-1:0] bh_wa;
   logic [LW-1:0] bh_wd;
   logic [LW-1:0] bh_rd;
   logic          ln_we;
   logic [EW-1:0] ln_wa;
   logic [LW-1:0] ln_wd;
   logic [EW-1:0] ln_ra;
   logic [LW-1:0] ln_rd;
   logic          ent_we;
   logic [63:0]   ek_rd;
   logic [63:0]   ev_rd;

   assign key_mix = key_ff ^ (key_ff >> HASH_PRE_SHIFT);
   assign prod_in = key_mix[HW-1:0] * MUL_LO;
   assign folded = prod_ff ^ (prod_ff >> HASH_POST_SHIFT);
   assign bkt_idx = folded[BW-1:0];

   assign free_ok = free_ff < NULL_LINK;
   assign fresh_ok = fresh_ff < NULL_LINK;
   assign slot_ok = free_ok || fresh_ok;
   assign slot = free_ok ? free_ff : fresh_ff;
   assign prev_null = !(prev_ff < NULL_LINK);

   always_comb begin
      bh_we = 1'b0;
      bh_wa = bkt_ff;
      bh_wd = NULL_LINK;
      if (cmd.clr_step) begin
         bh_we = 1'b1;
         bh_wa = clr_ff;
      end else if (cmd.ins_wr && slot_ok) begin
         bh_we = 1'b1;
         bh_wd = slot;
      end else if (cmd.unlink && prev_null) begin
         bh_we = 1'b1;
         bh_wd = nxt_ff;
      end
   end

   always_comb begin
      ln_we = 1'b0;
      ln_wa = cur_ff[EW-1:0];
      ln_wd = free_ff;
      if (cmd.ins_wr && slot_ok) begin
         ln_we = 1'b1;
         ln_wa = slot[EW-1:0];
         ln_wd = bh_rd;
      end else if (cmd.unlink && !prev_null) begin
         ln_we = 1'b1;
         ln_wa = prev_ff[EW-1:0];
         ln_wd = nxt_ff;
      end else if (cmd.free_wr) begin
         ln_we = 1'b1;
      end
   end

   assign ln_ra = cmd.head_rd ? free_ff[EW-1:0] : cur_ff[EW-1:0];
   assign ent_we = cmd.ins_wr && slot_ok;

   phm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bh_we),
      .wr_addr (bh_wa),
      .wr_data (bh_wd),
      .rd_addr (bkt_idx),
      .rd_data (bh_rd)
   );

   phm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram (
      .clock   (clock),
      .wr_en   (ln_we),
      .wr_addr (ln_wa),
      .wr_data (ln_wd),
      .rd_addr (ln_ra),
      .rd_data (ln_rd)
   );

   phm_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (slot[EW-1:0]),
      .wr_data (key_ff),
      .rd_addr (cur_ff[EW-1:0]),
      .rd_data (ek_rd)
   );

   phm_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_value_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (slot[EW-1:0]),
      .wr_data (val_ff),
      .rd_addr (cur_ff[EW-1:0]),
      .rd_data (ev_rd)
   );

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_command;
         key_ff <= req_key;
         val_ff <= req_value;
         found_ff <= '0;
         status_ff <= ST_DONE;
      end
      if (cmd.hash) begin
         prod_ff <= prod_in;
      end
      if (cmd.head_rd) begin
         bkt_ff <= bkt_idx;
      end
      if (cmd.ins_wr && !slot_ok) begin
         status_ff <= ST_FULL;
      end
      if (cmd.miss) begin
         status_ff <= ST_ABSENT;
      end
      if (cmd.walk_start) begin
         cur_ff <= bh_rd;
         prev_ff <= NULL_LINK;
      end
      if (cmd.node_rd) begin
         nxt_ff <= nxt_ff;
      end
      if (cmd.advance) begin
         prev_ff <= cur_ff;
         cur_ff <= ln_rd;
      end
      if (!cmd.node_rd && !cmd.advance && !cmd.walk_start && !cmd.unlink
          && !cmd.free_wr) begin
         nxt_ff <= ln_rd;
      end
      if (cmd.found_ld) begin
         found_ff <= ev_rd;
      end
      if (cmd.rsp_ld) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff <= found_ff;
         rsp_tail_ff <= tail_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         free_ff <= NULL_LINK;
         fresh_ff <= '0;
         tail_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.ins_wr && slot_ok) begin
            if (free_ok) begin
               free_ff <= ln_rd;
            end else begin
               fresh_ff <= fresh_ff + 1'b1;
            end
         end
         if (cmd.free_wr) begin
            free_ff <= cur_ff;
         end
         if (cmd.tail_wr) begin
            tail_ff <= val_ff;
         end
         if (cmd.rsp_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.clr_last = clr_ff == BW'(BUCKETS - 1);
   assign sts.op = op_ff;
   assign sts.cur_null = !(cur_ff < NULL_LINK);
   assign sts.key_eq = ek_rd == key_ff;
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_tail_value = rsp_tail_ff;

endmodule
`default_nettype wire

// ===== tb/tb_pointer_keyed_hash_map_core.sv =====
// ---------------------------------------------------------------------------
// tb_pointer_keyed_hash_map_core
// checks the chained hash map core against a behavioral map kept in the
// bench: every command word is predicted when taken and each response word
// is compared field by field with the oldest prediction
// ---------------------------------------------------------------------------
module tb_pointer_keyed_hash_map_core;
   import phm_pkg::*;

   localparam int BUCKETS = 256;
   localparam int ENTRIES = 256;
   localparam logic [8:0] NIL = 9'(ENTRIES);

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] found;
      logic [63:0] tail;
   } map_answer_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [127:0]  req_tdata;
   logic [1:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [127:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;

   pointer_keyed_hash_map_core #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // shadow of the map
   logic [8:0]  head_mem[BUCKETS];
   logic [63:0] key_mem[ENTRIES];
   logic [63:0] val_mem[ENTRIES];
   logic [8:0]  link_mem[ENTRIES];
   logic [8:0]  free_head;
   int          fresh_cnt;
   logic [63:0] tail_reg;

   map_answer_type answers_q[$];
   logic [63:0] keys_in_use[$];
   int          errors;
   int          words_sent;
   int          words_checked;
   int          full_seen;
   int          absent_seen;

   function automatic logic [7:0] bucket_index(logic [63:0] k);
      logic [63:0] h;
      h = k ^ (k >> 15);
      h = h * 64'h2545_F491_4F6C_DD1D;
      h = h ^ (h >> 13);
      return h[7:0];
   endfunction

   function automatic map_answer_type predict_map(logic [1:0] op, logic [63:0] k,
                                                  logic [63:0] v);
      map_answer_type a;
      logic [7:0]  b;
      logic [8:0]  slot;
      logic [8:0]  n;
      logic [8:0]  prev;
      a = '0;
      b = bucket_index(k);
      case (op)
         OP_INSERT: begin
            slot = NIL;
            if (free_head != NIL) begin
               slot = free_head;
               free_head = link_mem[slot];
            end else if (fresh_cnt < ENTRIES) begin
               slot = 9'(fresh_cnt);
               fresh_cnt++;
            end
            if (slot != NIL) begin
               key_mem[slot] = k;
               val_mem[slot] = v;
               link_mem[slot] = head_mem[b];
               head_mem[b] = slot;
            end else begin
               a.status = ST_FULL;
            end
            tail_reg = v;
         end
         OP_LOOKUP: begin
            a.status = ST_ABSENT;
            n = head_mem[b];
            while (n != NIL) begin
               if (key_mem[n] == k) begin
                  a.found = val_mem[n];
                  a.status = ST_DONE;
                  break;
               end
               n = link_mem[n];
            end
         end
         OP_REMOVE: begin
            a.status = ST_ABSENT;
            prev = NIL;
            n = head_mem[b];
            while (n != NIL) begin
               if (key_mem[n] == k) begin
                  if (prev != NIL) link_mem[prev] = link_mem[n];
                  else head_mem[b] = link_mem[n];
                  link_mem[n] = free_head;
                  free_head = n;
                  a.status = ST_DONE;
                  break;
               end
               prev = n;
               n = link_mem[n];
            end
         end
         default: tail_reg = v;
      endcase
      a.tail = tail_reg;
      return a;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end

   // response stall pattern, with quiet stretches
   int stall_mode;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      map_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_checked++;
         if (answers_q.size() == 0) begin
            $display("response word with nothing expected");
            errors++;
         end else begin
            want = answers_q.pop_front();
            if (rsp_tuser != want.status)
               report_mismatch("status", 64'(rsp_tuser), 64'(want.status));
            if (rsp_tdata[63:0] != want.found)
               report_mismatch("found_value", rsp_tdata[63:0], want.found);
            if (rsp_tdata[127:64] != want.tail)
               report_mismatch("tail_value", rsp_tdata[127:64], want.tail);
            if (want.status == ST_FULL) full_seen++;
            if (want.status == ST_ABSENT) absent_seen++;
         end
      end
   end

   int burst_left;

   task automatic send_word(logic [1:0] op, logic [63:0] k, logic [63:0] v);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {v, k};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      answers_q.push_back(predict_map(op, k, v));
      if (op == OP_INSERT) keys_in_use.push_back(k);
      words_sent++;
   endtask

   task automatic idle_sender();
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // keys that share bucket 0 build long chains
   function automatic logic [63:0] colliding_key();
      logic [63:0] k;
      do k = rand64(); while (bucket_index(k) != 8'd0);
      return k;
   endfunction

   task automatic test_directed();
      logic [63:0] c1;
      logic [63:0] c2;
      c1 = colliding_key();
      c2 = colliding_key();
      send_word(OP_LOOKUP, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(OP_REMOVE, '1, '1);
      send_word(OP_SET_TAIL, '1, '1);
      send_word(OP_SET_TAIL, 64'd0, 64'd0);
      send_word(OP_INSERT, 64'd0, '1);
      send_word(OP_INSERT, '1, 64'd0);
      send_word(OP_LOOKUP, 64'd0, 64'd0);
      send_word(OP_LOOKUP, '1, 64'd0);
      send_word(OP_INSERT, 64'd0, 64'h5555_AAAA_5555_AAAA);
      send_word(OP_LOOKUP, 64'd0, 64'd0);
      send_word(OP_REMOVE, 64'd0, 64'd0);
      send_word(OP_LOOKUP, 64'd0, 64'd0);
      send_word(OP_INSERT, c1, 64'h1);
      send_word(OP_INSERT, c2, 64'h2);
      send_word(OP_INSERT, c1, 64'h3);
      send_word(OP_REMOVE, c2, 64'd0);
      send_word(OP_LOOKUP, c1, 64'd0);
      send_word(OP_REMOVE, c1, 64'd0);
      send_word(OP_LOOKUP, c1, 64'd0);
      send_word(OP_REMOVE, c1, 64'd0);
      send_word(OP_REMOVE, c1, 64'd0);
      send_word(OP_LOOKUP, c2, 64'd0);
   endtask

   task automatic test_random_mix(int count);
      logic [1:0]  op;
      logic [63:0] k;
      int          r;
      repeat (count) begin
         r = $urandom_range(0, 99);
         op = (r < 40) ? OP_INSERT : (r < 70) ? OP_LOOKUP : (r < 92) ? OP_REMOVE
              : OP_SET_TAIL;
         if (keys_in_use.size() > 0 && $urandom_range(0, 3) != 0)
            k = keys_in_use[$urandom_range(0, keys_in_use.size() - 1)];
         else if ($urandom_range(0, 5) == 0)
            k = colliding_key();
         else
            k = rand64();
         if (op == OP_LOOKUP && $urandom_range(0, 4) == 0) k = rand64();
         send_word(op, k, rand64());
         if (stall_mode != 0 && $urandom_range(0, 60) == 0) stall_mode = 0;
         else if ($urandom_range(0, 60) == 0) stall_mode = $urandom_range(0, 2);
      end
   endtask

   // fill the pool past its size to hit dropped inserts, then look up and remove some keys
   task automatic test_pool_full();
      int i;
      for (i = 0; i < ENTRIES + 8; i++)
         send_word(OP_INSERT, ($urandom_range(0, 3) == 0) ? colliding_key() : rand64(),
                   rand64());
      for (i = 0; i < 40; i++)
         send_word(OP_LOOKUP, keys_in_use[$urandom_range(0, keys_in_use.size() - 1)],
                   rand64());
      for (i = 0; i < 60; i++)
         send_word(OP_REMOVE, keys_in_use[$urandom_range(0, keys_in_use.size() - 1)],
                   rand64());
   endtask

   initial begin
      int i;
      for (i = 0; i < BUCKETS; i++) head_mem[i] = NIL;
      free_head = NIL;
      fresh_cnt = 0;
      tail_reg = '0;
      errors = 0;
      words_sent = 0;
      words_checked = 0;
      full_seen = 0;
      absent_seen = 0;
      burst_left = 0;
      stall_mode = 1;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= OP_INSERT;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix(250);
      test_pool_full();
      test_random_mix(120);
      idle_sender();
      i = 0;
      while (answers_q.size() != 0 && i < 100000) begin
         @(posedge clock);
         i++;
      end
      repeat (50) @(posedge clock);
      if (answers_q.size() != 0) begin
         $display("%0d responses never arrived", answers_q.size());
         errors++;
      end
      $display("sent %0d commands, checked %0d responses", words_sent, words_checked);
      $display("pool full drops %0d, absent keys %0d, mismatches %0d",
               full_seen, absent_seen, errors);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
